// ===== hw/rtl/u2fat_pkg.sv =====
package u2fat_pkg;

    // Program counter of the control store
    localparam int unsigned PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_DIV,
        OP_SAVE_SEC,
        OP_SAVE_MIN,
        OP_SAVE_HOUR,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_SUB_OK,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic {
        DIV_BY_60,
        DIV_BY_24
    } t_dsel;

    typedef struct packed {
        t_op   op;
        t_dsel dsel;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        t_op   op;
        t_dsel dsel;
    } t_ctrl;

    // datapath -> sequencer
    typedef struct packed {
        logic sub_ok;
    } t_flags;

    // Program step addresses
    localparam t_pc PC_WAIT      = 4'd0;
    localparam t_pc PC_DIV_SEC   = 4'd1;
    localparam t_pc PC_SAVE_SEC  = 4'd2;
    localparam t_pc PC_DIV_MIN   = 4'd3;
    localparam t_pc PC_SAVE_MIN  = 4'd4;
    localparam t_pc PC_DIV_HOUR  = 4'd5;
    localparam t_pc PC_SAVE_HOUR = 4'd6;
    localparam t_pc PC_YEAR      = 4'd7;
    localparam t_pc PC_MONTH     = 4'd8;
    localparam t_pc PC_EMIT      = 4'd9;
    localparam t_pc PC_RESTART   = 4'd10;

    localparam logic [6:0]  DIVISOR_60    = 7'd60;
    localparam logic [6:0]  DIVISOR_24    = 7'd24;
    // reciprocals: x / 60 = (x * MAGIC_60) >> 37, x / 24 = (x * MAGIC_24) >> 36
    localparam logic [31:0] MAGIC_60      = 32'h8888_8889;
    localparam logic [31:0] MAGIC_24      = 32'hAAAA_AAAB;
    localparam logic [8:0]  YEAR_LEN      = 9'd365;
    localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
    localparam logic [7:0]  YOFF_FAT_BASE = 8'd10;   // 1980 - 1970
    localparam logic [7:0]  YOFF_2100     = 8'd130;  // only skipped century in range
    localparam logic [3:0]  LAST_MONTH    = 4'd11;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: OP_NOP, dsel: DIV_BY_60, cond: C_ALWAYS, target: PC_WAIT};
        case (pc)
            PC_WAIT:      w = '{op: OP_WAIT,      dsel: DIV_BY_60, cond: C_NO_INPUT,
                                target: PC_WAIT};
            PC_DIV_SEC:   w = '{op: OP_DIV,       dsel: DIV_BY_60, cond: C_NEXT,
                                target: PC_WAIT};
            PC_SAVE_SEC:  w = '{op: OP_SAVE_SEC,  dsel: DIV_BY_60, cond: C_NEXT,
                                target: PC_WAIT};
            PC_DIV_MIN:   w = '{op: OP_DIV,       dsel: DIV_BY_60, cond: C_NEXT,
                                target: PC_WAIT};
            PC_SAVE_MIN:  w = '{op: OP_SAVE_MIN,  dsel: DIV_BY_60, cond: C_NEXT,
                                target: PC_WAIT};
            PC_DIV_HOUR:  w = '{op: OP_DIV,       dsel: DIV_BY_24, cond: C_NEXT,
                                target: PC_WAIT};
            PC_SAVE_HOUR: w = '{op: OP_SAVE_HOUR, dsel: DIV_BY_24, cond: C_NEXT,
                                target: PC_WAIT};
            PC_YEAR:      w = '{op: OP_YEAR,      dsel: DIV_BY_60, cond: C_SUB_OK,
                                target: PC_YEAR};
            PC_MONTH:     w = '{op: OP_MONTH,     dsel: DIV_BY_60, cond: C_SUB_OK,
                                target: PC_MONTH};
            PC_EMIT:      w = '{op: OP_EMIT,      dsel: DIV_BY_60, cond: C_OUT_BUSY,
                                target: PC_EMIT};
            PC_RESTART:   w = '{op: OP_NOP,       dsel: DIV_BY_60, cond: C_ALWAYS,
                                target: PC_WAIT};
            default:      w = '{op: OP_NOP,       dsel: DIV_BY_60, cond: C_ALWAYS,
                                target: PC_WAIT};
        endcase
        return w;
    endfunction

    // yoff = year - 1970; exact for 1970..2106
    function automatic logic is_leap(input logic [7:0] yoff);
        return (yoff[1:0] == 2'd2) && (yoff != YOFF_2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m0, input logic leap);
        logic [4:0] d;
        case (m0)
            4'd0:    d = 5'd31;
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd2:    d = 5'd31;
            4'd3:    d = 5'd30;
            4'd4:    d = 5'd31;
            4'd5:    d = 5'd30;
            4'd6:    d = 5'd31;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd30;
            4'd9:    d = 5'd31;
            4'd10:   d = 5'd30;
            4'd11:   d = 5'd31;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/unix_seconds_to_fat_timestamp_unit.sv =====
// Channel   Dir  Word                          Width
// s_axis    in   local_seconds                 32
// m_axis    out  fat_timestamp                 32
//
// A microcoded sequencer runs each word: three divisions (by 60, 60, 24), each a
// reciprocal-multiply step and a remainder step, then a year step per whole year
// from 1970 and a month step per whole month, each loop ending on a failed test.
// Reset clears the step counter and the output valid; no clearing pass.
// A new word is taken only at the wait step; a result waiting in the output
// register does not hold the next conversion until it must be written.
module unix_seconds_to_fat_timestamp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] local_seconds
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] fat_timestamp
);

    u2fat_pkg::t_ctrl  w_ctrl;
    u2fat_pkg::t_flags w_flags;
    logic [31:0]       w_result;
    logic              w_out_busy;
    logic              w_accept;
    logic              r_out_valid;
    logic [31:0]       r_out_data;

    assign o_s_axis_tready = (w_ctrl.op == u2fat_pkg::OP_WAIT);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_busy      = r_out_valid && !i_m_axis_tready;

    u2fat_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_busy (w_out_busy),
        .i_flags    (w_flags),
        .o_ctrl     (w_ctrl)
    );

    u2fat_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_load    (w_accept),
        .i_seconds (i_s_axis_tdata),
        .o_flags   (w_flags),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_ctrl.op == u2fat_pkg::OP_EMIT) && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_ctrl.op == u2fat_pkg::OP_EMIT) && !w_out_busy) begin
            r_out_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/u2fat_seq.sv =====
module u2fat_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_busy,
    input  u2fat_pkg::t_flags i_flags,
    output u2fat_pkg::t_ctrl  o_ctrl
);

    u2fat_pkg::t_pc    r_pc;
    u2fat_pkg::t_pc    n_pc;
    u2fat_pkg::t_uword w_uw;
    logic              w_take;

    assign w_uw = u2fat_pkg::ucode(r_pc);

    always_comb begin
        case (w_uw.cond)
            u2fat_pkg::C_NEXT:     w_take = 1'b0;
            u2fat_pkg::C_ALWAYS:   w_take = 1'b1;
            u2fat_pkg::C_NO_INPUT: w_take = !i_in_valid;
            u2fat_pkg::C_SUB_OK:   w_take = i_flags.sub_ok;
            u2fat_pkg::C_OUT_BUSY: w_take = i_out_busy;
            default:               w_take = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = w_take ? w_uw.target : r_pc + u2fat_pkg::t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= u2fat_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = '{op: w_uw.op, dsel: w_uw.dsel};

endmodule

// ===== hw/rtl/u2fat_dp.sv =====
module u2fat_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  u2fat_pkg::t_ctrl  i_ctrl,
    input  logic              i_load,
    input  logic [31:0]       i_seconds,
    output u2fat_pkg::t_flags o_flags,
    output logic [31:0]       o_result
);

    logic [31:0] r_acc;
    logic [31:0] r_quo;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [7:0]  r_year;
    logic [3:0]  r_month;

    logic [6:0]  w_divisor;
    logic [31:0] w_magic;
    logic [63:0] w_prod;
    logic [31:0] w_quo;
    logic [11:0] w_qprod;
    logic [5:0]  w_rem;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;
    logic        w_year_ok;
    logic        w_month_ok;
    logic [7:0]  w_ydiff;
    logic [4:0]  w_day;

    assign w_divisor = (i_ctrl.dsel == u2fat_pkg::DIV_BY_24) ? u2fat_pkg::DIVISOR_24
                                                             : u2fat_pkg::DIVISOR_60;
    assign w_magic   = (i_ctrl.dsel == u2fat_pkg::DIV_BY_24) ? u2fat_pkg::MAGIC_24
                                                             : u2fat_pkg::MAGIC_60;
    // quotient by reciprocal multiply
    assign w_prod    = {32'd0, r_acc} * {32'd0, w_magic};
    assign w_quo     = (i_ctrl.dsel == u2fat_pkg::DIV_BY_24) ? {4'd0, w_prod[63:36]}
                                                             : {5'd0, w_prod[63:37]};
    // remainder is below 64, so only the low six bits matter
    assign w_qprod   = {6'd0, r_quo[5:0]} * {5'd0, w_divisor};
    assign w_rem     = r_acc[5:0] - w_qprod[5:0];

    assign w_leap     = u2fat_pkg::is_leap(r_year);
    assign w_ylen     = w_leap ? u2fat_pkg::LEAP_YEAR_LEN : u2fat_pkg::YEAR_LEN;
    assign w_mlen     = u2fat_pkg::month_len(r_month, w_leap);
    assign w_year_ok  = (r_acc >= {23'd0, w_ylen});
    assign w_month_ok = (r_month < u2fat_pkg::LAST_MONTH) && (r_acc >= {27'd0, w_mlen});

    always_comb begin
        case (i_ctrl.op)
            u2fat_pkg::OP_YEAR:  o_flags.sub_ok = w_year_ok;
            u2fat_pkg::OP_MONTH: o_flags.sub_ok = w_month_ok;
            default:             o_flags.sub_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            u2fat_pkg::OP_WAIT: begin
                if (i_load) begin
                    r_acc   <= i_seconds;
                    r_year  <= '0;
                    r_month <= '0;
                end
            end
            u2fat_pkg::OP_DIV: begin
                r_quo <= w_quo;
            end
            u2fat_pkg::OP_SAVE_SEC: begin
                r_sec <= w_rem;
                r_acc <= r_quo;
            end
            u2fat_pkg::OP_SAVE_MIN: begin
                r_min <= w_rem;
                r_acc <= r_quo;
            end
            u2fat_pkg::OP_SAVE_HOUR: begin
                r_hour <= w_rem[4:0];
                r_acc  <= r_quo;
            end
            u2fat_pkg::OP_YEAR: begin
                if (w_year_ok) begin
                    r_acc  <= r_acc - {23'd0, w_ylen};
                    r_year <= r_year + 8'd1;
                end
            end
            u2fat_pkg::OP_MONTH: begin
                if (w_month_ok) begin
                    r_acc   <= r_acc - {27'd0, w_mlen};
                    r_month <= r_month + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_ydiff = r_year - u2fat_pkg::YOFF_FAT_BASE;
    assign w_day   = r_acc[4:0] + 5'd1;

    // years before 1980 (zero input included) give an all-zero word
    always_comb begin
        if (r_year < u2fat_pkg::YOFF_FAT_BASE) begin
            o_result = '0;
        end else begin
            o_result = {w_ydiff[6:0], r_month + 4'd1, w_day,
                        r_hour, r_min, r_sec[5:1]};
        end
    end

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_ctrl.op == u2fat_pkg::OP_SAVE_SEC) || (i_ctrl.op == u2fat_pkg::OP_SAVE_MIN) ||
         (i_ctrl.op == u2fat_pkg::OP_SAVE_HOUR)) |-> ({1'b0, w_rem} < w_divisor))
        else $error("division remainder out of range");

    a_year_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == u2fat_pkg::OP_YEAR) && w_year_ok |=> (r_year == $past(r_year) + 8'd1))
        else $error("year counter did not advance");

    a_day_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == u2fat_pkg::OP_EMIT) |->
            (r_acc < 32'd31) && (r_month <= u2fat_pkg::LAST_MONTH))
        else $error("day or month out of range at emit");
`endif

endmodule
